// ===== rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constant table, initial hash values and the controller state type.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_sched.sv =====
// Message schedule for the SHA-256 stream hasher: a 16-word memory.
// Holds the block words; the expansion runs in the register window of the top level.
module sha256_sched (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sha256_round.sv =====
// One SHA-256 round.
// Pure combinational datapath; uses sha256_pkg for the rotate helper.
module sha256_round (
  input  logic [31:0] v_in   [8],
  input  logic [31:0] k_word,
  input  logic [31:0] w_word,
  output logic [31:0] v_out  [8]
);

  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    t1 = v_in[7]
       + (sha256_pkg::ror32(v_in[4], 6) ^ sha256_pkg::ror32(v_in[4], 11)
          ^ sha256_pkg::ror32(v_in[4], 25))
       + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]))
       + k_word + w_word;
    t2 = (sha256_pkg::ror32(v_in[0], 2) ^ sha256_pkg::ror32(v_in[0], 13)
          ^ sha256_pkg::ror32(v_in[0], 22))
       + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: byte packing, padding, round control and output.
// Uses sha256_pkg, sha256_sched and sha256_round.
//
//   channel | ports                                             | direction
//   in      | in_valid, in_stall, in_data_byte, in_byte_present, | into the block
//           | in_end_of_message                                  |
//   out     | out_valid, out_stall, out_digest_word,             | out of the block
//           | out_word_number, out_final_word                    |
//
// A 64th byte starts a compression that keeps in_stall high while the block words are
// loaded from the schedule memory into a 16-word register window and 64 rounds run at
// one per cycle. A final request pads one byte per cycle, writes the length as two words,
// runs one or two compressions and then gives eight result words, each held while
// out_stall is high. Reset restores the initial hash and clears the byte count.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_final_word
);

  sha256_pkg::state_t state_r, state_nxt;

  logic [31:0] chain_r   [8];
  logic [31:0] vars_r    [8];
  logic [31:0] vars_nxt  [8];
  logic [31:0] win_r     [16];
  logic [31:0] pack_r;
  logic [63:0] total_r;
  logic [5:0]  pos_r;
  logic [6:0]  round_r;
  logic        last_r;
  logic [2:0]  emit_r;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] sg0;
  logic [31:0] sg1;
  logic [31:0] pack_word;
  logic [31:0] word_fill;
  logic        accept;
  logic        rd_en;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic [7:0]  byte_in;
  logic [1:0]  lane;
  logic        byte_step;
  // pad_more marks that a second block follows the one now compressed.
  logic        pad_more_r;
  // len_done marks that the length words went into the block just compressed.
  logic        len_done_r;

  assign accept = in_valid && !in_stall;

  // The window holds the sixteen most recent schedule words; the memory keeps the block.
  sha256_sched u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sg0 = sha256_pkg::ror32(win_r[1], 7) ^ sha256_pkg::ror32(win_r[1], 18)
             ^ (win_r[1] >> 3);
  assign sg1 = sha256_pkg::ror32(win_r[14], 17) ^ sha256_pkg::ror32(win_r[14], 19)
             ^ (win_r[14] >> 10);
  assign w_new = win_r[0] + sg0 + win_r[9] + sg1;
  assign w_cur = win_r[0];

  sha256_round u_round (
    .v_in   (vars_r),
    .k_word (sha256_pkg::ROUND_K[round_r[5:0]]),
    .w_word (w_cur),
    .v_out  (vars_nxt)
  );

  // Byte merge into the word being packed.
  assign lane = pos_r[1:0];
  always_comb begin
    priority if (state_r == sha256_pkg::ST_PAD) begin
      byte_in = (pos_r == total_r[5:0]) ? sha256_pkg::PAD_BYTE : 8'h00;
    end else begin
      byte_in = in_data_byte;
    end
    word_fill = (lane == 2'd0) ? 32'h0 : pack_r;
    unique case (lane)
      2'd0: pack_word = {byte_in, word_fill[23:0]};
      2'd1: pack_word = {word_fill[31:24], byte_in, word_fill[15:0]};
      2'd2: pack_word = {word_fill[31:16], byte_in, word_fill[7:0]};
      default: pack_word = {word_fill[31:8], byte_in};
    endcase
  end

  assign byte_step = (accept && in_byte_present) || (state_r == sha256_pkg::ST_PAD);

  // Memory port control: block words are written as they complete, the length words in
  // the length state, and all are read back into the window as a compression begins.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[5:2];
    wr_data = pack_word;
    rd_en   = 1'b0;
    rd_addr = round_r[3:0];
    priority if (byte_step) begin
      wr_en = (lane == 2'd3);
    end else if (state_r == sha256_pkg::ST_LEN) begin
      wr_en   = 1'b1;
      wr_addr = round_r[0] ? 4'd15 : 4'd14;
      wr_data = round_r[0] ? {total_r[28:0], 3'b000} : {total_r[60:29]};
    end
    if (state_r == sha256_pkg::ST_FOLD) begin
      rd_en = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_byte_present && pos_r == 6'd63) begin
            state_nxt = sha256_pkg::ST_FOLD;
          end else if (in_end_of_message) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (pos_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_FOLD;
        end else if (pos_r == 6'd55) begin
          state_nxt = sha256_pkg::ST_LEN;
        end
      end
      sha256_pkg::ST_LEN: begin
        if (round_r[0]) begin
          state_nxt = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        if (round_r == 7'd16) begin
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (round_r == 7'd63) begin
          if (!last_r) begin
            state_nxt = sha256_pkg::ST_IDLE;
          end else if (pad_more_r || !len_done_r) begin
            state_nxt = sha256_pkg::ST_PAD;
          end else begin
            state_nxt = sha256_pkg::ST_EMIT;
          end
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (!out_stall && emit_r == 3'd7) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_stall        = (state_r != sha256_pkg::ST_IDLE);
    out_valid       = (state_r == sha256_pkg::ST_EMIT);
    out_digest_word = chain_r[emit_r];
    out_word_number = emit_r;
    out_final_word  = (emit_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256_pkg::ST_IDLE;
      total_r    <= 64'd0;
      pos_r      <= 6'd0;
      round_r    <= 7'd0;
      last_r     <= 1'b0;
      pad_more_r <= 1'b0;
      emit_r     <= 3'd0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha256_pkg::INIT_H[i];
    end else begin
      state_r <= state_nxt;
      if (byte_step) begin
        pack_r <= pack_word;
        pos_r  <= pos_r + 6'd1;
      end
      unique case (state_r)
        sha256_pkg::ST_IDLE: begin
          round_r <= 7'd0;
          if (accept) begin
            last_r <= in_end_of_message;
            if (in_byte_present) begin
              total_r <= total_r + 64'd1;
            end
            // A final byte landing at 55 or later, or an end at a count above 55, forces a second padded block.
            pad_more_r <= in_end_of_message
                        && ((in_byte_present ? total_r[5:0] + 6'd1 : total_r[5:0]) > 6'd55
                            || (in_byte_present && total_r[5:0] == 6'd63));
          end
        end
        sha256_pkg::ST_PAD: begin
          round_r <= 7'd0;
        end
        sha256_pkg::ST_LEN: begin
          if (round_r[0]) begin
            round_r <= 7'd0;
            pos_r   <= 6'd0;
          end else begin
            round_r <= round_r + 7'd1;
          end
        end
        sha256_pkg::ST_FOLD: begin
          if (round_r == 7'd0) begin
            for (int i = 0; i < 8; i++) vars_r[i] <= chain_r[i];
          end
          if (round_r != 7'd0) begin
            for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
            win_r[15] <= rd_data;
          end
          round_r <= (round_r == 7'd16) ? 7'd0 : round_r + 7'd1;
        end
        sha256_pkg::ST_ROUND: begin
          vars_r <= vars_nxt;
          for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
          win_r[15] <= w_new;
          if (round_r == 7'd63) begin
            round_r    <= 7'd0;
            pad_more_r <= 1'b0;
            for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + vars_nxt[i];
          end else begin
            round_r <= round_r + 7'd1;
          end
        end
        sha256_pkg::ST_EMIT: begin
          if (!out_stall) begin
            emit_r <= emit_r + 3'd1;
            if (emit_r == 3'd7) begin
              total_r    <= 64'd0;
              pos_r      <= 6'd0;
              last_r     <= 1'b0;
              pad_more_r <= 1'b0;
              for (int i = 0; i < 8; i++) chain_r[i] <= sha256_pkg::INIT_H[i];
            end
          end
        end
        default: round_r <= 7'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_done_r <= 1'b0;
    end else if (state_r == sha256_pkg::ST_LEN) begin
      len_done_r <= 1'b1;
    end else if (state_r == sha256_pkg::ST_EMIT || state_r == sha256_pkg::ST_IDLE) begin
      len_done_r <= 1'b0;
    end
  end

  // The padding state starts with the 0x80 byte at the byte count; a block that ends
  // padding below byte 56 goes to the length state, otherwise pads to 64 and compresses.

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sha256_pkg::ST_IDLE) |-> !accept)
    else $error("request accepted while busy");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && emit_r != 3'd7)
      |=> (out_valid && out_word_number == $past(emit_r) + 3'd1))
    else $error("digest words out of order");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256_pkg::ST_ROUND) |-> (round_r <= 7'd63))
    else $error("round counter overrun");

endmodule
